### rtl/bdq_pkg.sv
// Shared types and constants for the bounded deque with scans.
`timescale 1ns / 1ps

package bdq_pkg;

	localparam int DEF_CAPACITY   = 16;
	localparam int DEF_DATA_WIDTH = 32;

	localparam int CMD_W     = 3;
	localparam int VALUE_W   = 32;
	localparam int STATUS_W  = 2;
	localparam int LEN_W     = 5;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 80;

	typedef enum logic [CMD_W-1:0] {
		CMD_PUSH_FRONT = 3'd0,
		CMD_PUSH_BACK  = 3'd1,
		CMD_POP_FRONT  = 3'd2,
		CMD_POP_BACK   = 3'd3,
		CMD_COUNT      = 3'd4,
		CMD_MIN_MAX    = 3'd5,
		CMD_SORTED     = 3'd6
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK    = 2'd0,
		STS_EMPTY = 2'd1,
		STS_FULL  = 2'd2
	} status_t;

	// Per-cell storage control, one update at most per cycle.
	typedef struct packed {
		logic shift_r;   // push front: take left neighbor
		logic shift_l;   // pop front: take right neighbor
		logic load;      // push back: take new word
	} cell_ctl_t;

	// Control bits traveling with a scan down the chain.
	typedef struct packed {
		logic valid;
		logic seen;      // at least one held entry visited
		logic asc;       // order still non-decreasing
	} scan_tag_t;

	// Result transaction, status in the lowest bits.
	typedef struct packed {
		logic                      ascending;
		logic signed [VALUE_W-1:0] max_value;
		logic signed [VALUE_W-1:0] min_value;
		logic [LEN_W-1:0]          match_count;
		logic [LEN_W-1:0]          length;
		status_t                   status;
	} result_t;

endpackage

### rtl/bdq_cell.sv
// One deque cell: a stored entry plus one stage of the scan pipeline.
`timescale 1ns / 1ps

module bdq_cell import bdq_pkg::*; #(
	parameter int DATA_WIDTH = DEF_DATA_WIDTH,
	parameter int CNT_W      = 5
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  cell_ctl_t                    ctl,
	input  logic signed [DATA_WIDTH-1:0] word,
	input  logic signed [DATA_WIDTH-1:0] left_entry,
	input  logic signed [DATA_WIDTH-1:0] right_entry,
	output logic signed [DATA_WIDTH-1:0] entry,
	input  logic                         in_range,
	input  scan_tag_t                    tag_in,
	input  logic signed [DATA_WIDTH-1:0] key_in,
	input  logic [CNT_W-1:0]             cnt_in,
	input  logic signed [DATA_WIDTH-1:0] min_in,
	input  logic signed [DATA_WIDTH-1:0] max_in,
	input  logic signed [DATA_WIDTH-1:0] prev_in,
	output scan_tag_t                    tag_out,
	output logic signed [DATA_WIDTH-1:0] key_out,
	output logic [CNT_W-1:0]             cnt_out,
	output logic signed [DATA_WIDTH-1:0] min_out,
	output logic signed [DATA_WIDTH-1:0] max_out,
	output logic signed [DATA_WIDTH-1:0] prev_out
);

	logic signed [DATA_WIDTH-1:0] entry_q;
	scan_tag_t                    tag_q;
	logic signed [DATA_WIDTH-1:0] key_q, min_q, max_q, prev_q;
	logic [CNT_W-1:0]             cnt_q;

	scan_tag_t                    tag_d;
	logic signed [DATA_WIDTH-1:0] min_d, max_d, prev_d;
	logic [CNT_W-1:0]             cnt_d;

	always_ff @(posedge clk) begin
		priority if (ctl.shift_r) begin
			entry_q <= left_entry;
		end else if (ctl.shift_l) begin
			entry_q <= right_entry;
		end else if (ctl.load) begin
			entry_q <= word;
		end
	end

	always_comb begin
		tag_d  = tag_in;
		cnt_d  = cnt_in;
		min_d  = min_in;
		max_d  = max_in;
		prev_d = prev_in;
		if (in_range) begin
			cnt_d = cnt_in + CNT_W'(entry_q == key_in);
			if (!tag_in.seen) begin
				min_d = entry_q;
				max_d = entry_q;
			end else begin
				if (entry_q < min_in) min_d = entry_q;
				if (entry_q > max_in) max_d = entry_q;
				if (prev_in > entry_q) tag_d.asc = 1'b0;
			end
			prev_d     = entry_q;
			tag_d.seen = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else begin
			tag_q <= tag_d;
		end
	end

	always_ff @(posedge clk) begin
		key_q  <= key_in;
		cnt_q  <= cnt_d;
		min_q  <= min_d;
		max_q  <= max_d;
		prev_q <= prev_d;
	end

	assign entry    = entry_q;
	assign tag_out  = tag_q;
	assign key_out  = key_q;
	assign cnt_out  = cnt_q;
	assign min_out  = min_q;
	assign max_out  = max_q;
	assign prev_out = prev_q;

endmodule

### rtl/bounded_deque_with_scans.sv
// Top level of the bounded deque with count, min-max and sorted scans.
`timescale 1ns / 1ps

// Bounded deque of CAPACITY signed words, held in logical order in a row of
// cells: cell 0 is the front, cell length-1 the back.
// Input stream (s_*): one command transaction per item, cmd and value.
// Output stream (m_*): exactly one result transaction per command.
// Push front shifts every cell one place toward the back; pop front shifts
// toward the front; push back loads the cell at the current length; pop back
// only lowers the length. Push on full is dropped with status full; pop or
// min-max on empty report status empty.
// Count, min-max and sorted queries send a scan down the chain, one cell per
// cycle, so the cell chain sets their latency.
// Push, pop and unused codes pass from accept to the pending result register
// and then to the output register; the three scans first run the cell chain.
// One command is in flight at a time; a new command is taken once the previous
// result has moved into the output register, so a waiting result does not hold
// off the next accept.
// If the receiver stalls, the output register and one pending result hold,
// and s_tready stays low until the pending result drains.
// Reset (arst_n low) empties the deque; stored words are not cleared.
module bounded_deque_with_scans import bdq_pkg::*; #(
	parameter int CAPACITY   = DEF_CAPACITY,
	parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // cmd[2:0], value[34:3]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata    // status[1:0], length[6:2],
	                                        // match_count[11:7], min_value[43:12],
	                                        // max_value[75:44], ascending[76]
);

	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t               state_q;
	logic [CNT_W-1:0]     count_q;
	cmd_t                 cmd_q;
	result_t              res_q;
	result_t              out_q;
	logic                 m_tvalid_q;

	cmd_t                         in_cmd;
	logic signed [VALUE_W-1:0]    in_value;
	logic signed [DATA_WIDTH-1:0] word;
	logic                         accept, full, empty, is_scan;
	logic [CNT_W-1:0]             count_d;
	status_t                      acc_status;
	result_t                      acc_res;
	result_t                      scan_res;
	logic                         out_load;

	// Chain wiring; ent[i] comes from cell i; in the scan arrays index 0 is driven here, index i+1 by cell i.
	logic signed [DATA_WIDTH-1:0] ent  [CAPACITY];
	scan_tag_t                    tag_c [CAPACITY+1];
	logic signed [DATA_WIDTH-1:0] key_c [CAPACITY+1];
	logic [CNT_W-1:0]             cnt_c [CAPACITY+1];
	logic signed [DATA_WIDTH-1:0] min_c [CAPACITY+1];
	logic signed [DATA_WIDTH-1:0] max_c [CAPACITY+1];
	logic signed [DATA_WIDTH-1:0] prev_c[CAPACITY+1];

	assign in_cmd   = cmd_t'(s_tdata[CMD_W-1:0]);
	assign in_value = s_tdata[CMD_W+VALUE_W-1:CMD_W];
	assign word     = DATA_WIDTH'(in_value);

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign full     = (count_q == CNT_W'(CAPACITY));
	assign empty    = (count_q == '0);
	assign is_scan  = (in_cmd == CMD_COUNT) || (in_cmd == CMD_MIN_MAX) ||
	                  (in_cmd == CMD_SORTED);

	// Scan injection at the front of the chain.
	assign tag_c[0]  = '{valid: accept && is_scan, seen: 1'b0, asc: 1'b1};
	assign key_c[0]  = word;
	assign cnt_c[0]  = '0;
	assign min_c[0]  = '0;
	assign max_c[0]  = '0;
	assign prev_c[0] = '0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		cell_ctl_t                    ctl;
		logic signed [DATA_WIDTH-1:0] left_entry, right_entry;

		assign ctl.shift_r = accept && (in_cmd == CMD_PUSH_FRONT) && !full;
		assign ctl.shift_l = accept && (in_cmd == CMD_POP_FRONT) && !empty;
		assign ctl.load    = accept && (in_cmd == CMD_PUSH_BACK) && !full &&
		                     (count_q == CNT_W'(i));

		if (i == 0) begin : g_first
			assign left_entry = word;
		end else begin : g_mid_l
			assign left_entry = ent[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_entry = ent[i];
		end else begin : g_mid_r
			assign right_entry = ent[i+1];
		end

		bdq_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.CNT_W     (CNT_W)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.word       (word),
			.left_entry (left_entry),
			.right_entry(right_entry),
			.entry      (ent[i]),
			.in_range   (count_q > CNT_W'(i)),
			.tag_in     (tag_c[i]),
			.key_in     (key_c[i]),
			.cnt_in     (cnt_c[i]),
			.min_in     (min_c[i]),
			.max_in     (max_c[i]),
			.prev_in    (prev_c[i]),
			.tag_out    (tag_c[i+1]),
			.key_out    (key_c[i+1]),
			.cnt_out    (cnt_c[i+1]),
			.min_out    (min_c[i+1]),
			.max_out    (max_c[i+1]),
			.prev_out   (prev_c[i+1])
		);
	end

	// Length update and status for push and pop.
	always_comb begin
		count_d    = count_q;
		acc_status = STS_OK;
		unique case (in_cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (full) acc_status = STS_FULL;
				else count_d = count_q + CNT_W'(1);
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (empty) acc_status = STS_EMPTY;
				else count_d = count_q - CNT_W'(1);
			end
			default: begin
			end
		endcase
		acc_res        = '0;
		acc_res.status = acc_status;
		acc_res.length = LEN_W'(count_d);
	end

	// Result of a finished scan, taken from the end of the chain.
	always_comb begin
		scan_res        = '0;
		scan_res.length = LEN_W'(count_q);
		unique case (cmd_q)
			CMD_COUNT: scan_res.match_count = LEN_W'(cnt_c[CAPACITY]);
			CMD_MIN_MAX: begin
				if (empty) begin
					scan_res.status = STS_EMPTY;
				end else begin
					scan_res.min_value = VALUE_W'(min_c[CAPACITY]);
					scan_res.max_value = VALUE_W'(max_c[CAPACITY]);
				end
			end
			CMD_SORTED: scan_res.ascending = tag_c[CAPACITY].asc;
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == ST_DONE) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						count_q <= count_d;
						state_q <= is_scan ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (tag_c[CAPACITY].valid) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) m_tvalid_q <= 1'b1;
			else if (m_tready) m_tvalid_q <= 1'b0;
		end
	end

	// Pending result and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= in_cmd;
			res_q <= acc_res;
		end else if (state_q == ST_SCAN && tag_c[CAPACITY].valid) begin
			res_q <= scan_res;
		end
		if (out_load) out_q <= res_q;
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = M_TDATA_W'(out_q);

	// A scan only leaves the chain while the control waits for it.
	a_scan_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		tag_c[CAPACITY].valid |-> state_q == ST_SCAN)
		else $error("scan result outside scan state");

	// A successful push front grows the deque by one.
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_cmd == CMD_PUSH_FRONT && !full) |=>
		count_q == CNT_W'($past(count_q) + CNT_W'(1)))
		else $error("push front did not grow length");

	// Length never passes the capacity.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("length above capacity");

endmodule
